@@ design/fat32_chain_sector_stepper_top_macros.svh @@
// assertion macros for the fat32 chain sector stepper
// used by the top level, no other dependencies
`ifndef FAT32_CHAIN_SECTOR_STEPPER_TOP_MACROS_SVH
`define FAT32_CHAIN_SECTOR_STEPPER_TOP_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define FCSS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fcss check failed");

// next-cycle implication under synchronous active-low reset
`define FCSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fcss check failed");

`endif

@@ design/fcss_pkg.sv @@
// shared types and constants for the fat32 chain sector stepper
// no dependencies
package fcss_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int FAT_WORDS    = SECTOR_BYTES / 4;
    localparam int IDX_W        = $clog2(FAT_WORDS);
    localparam int APB_AW       = 4;

    localparam logic [31:0] ENTRY_MASK  = 32'h0fff_ffff;
    localparam logic [31:0] CLUSTER_MIN = 32'h0000_0002;
    localparam logic [31:0] CLUSTER_MAX = 32'h0fff_ffef;

    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_FILL    = 1'b1;

    typedef enum logic [2:0] {
        ST_SAME    = 3'd0,
        ST_CHAIN   = 3'd1,
        ST_END     = 3'd2,
        ST_FAT_REQ = 3'd3,
        ST_BUSY    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_DATA_START    = 2'd0,
        REG_FAT_LBA       = 2'd1,
        REG_CLUSTER_SHIFT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] data_start_lba;
        logic [31:0] fat_lba;
        logic [2:0]  cluster_shift;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] lba;
        logic [31:0] diff;
        logic [31:0] word;
    } item_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [31:0]      data;
    } cache_wr_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [31:0] next_sector;
        logic [31:0] fat_read_lba;
    } result_t;

    typedef struct packed {
        logic pending;
        logic filling;
    } core_stat_t;

endpackage

@@ design/fcss_apb_regs.sv @@
// apb configuration registers of the fat32 chain sector stepper
// depends on fcss_pkg
module fcss_apb_regs import fcss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_DATA_START:    cfg_reg.data_start_lba <= pwdata;
                REG_FAT_LBA:       cfg_reg.fat_lba        <= pwdata;
                REG_CLUSTER_SHIFT: cfg_reg.cluster_shift  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DATA_START:    prdata = cfg_reg.data_start_lba;
            REG_FAT_LBA:       prdata = cfg_reg.fat_lba;
            REG_CLUSTER_SHIFT: prdata = {29'd0, cfg_reg.cluster_shift};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

@@ design/fcss_fat_cache.sv @@
// one-sector fat cache memory with registered read and write bypass
// depends on fcss_pkg
module fcss_fat_cache import fcss_pkg::*; (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    input  cache_wr_t        wr,
    output logic [31:0]      rd_data
);

    logic [31:0] mem [FAT_WORDS];
    logic [31:0] rd_data_reg;
    logic [31:0] byp_data_reg;
    logic        byp_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            byp_reg      <= wr.en && (wr.addr == rd_addr);
            byp_data_reg <= wr.data;
        end
    end

    // word written in the read cycle wins over the stale array data
    assign rd_data = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

@@ design/fcss_step_core.sv @@
// step logic and chain state: cluster math, cache tag, fill tracking
// depends on fcss_pkg, writes the fat cache through a cache_wr_t
module fcss_step_core import fcss_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        exec,
    input  item_t       item,
    input  logic [31:0] cache_entry,
    output cache_wr_t   cache_wr,
    output result_t     result,
    output core_stat_t  stat
);

    logic             pending_reg, pending_next;
    logic             cache_valid_reg, cache_valid_next;
    logic [31:0]      cache_tag_reg, cache_tag_next;
    logic [31:0]      pend_cl_reg, pend_cl_next;
    logic [IDX_W-1:0] fill_count_reg, fill_count_next;
    logic [31:0]      pend_entry_reg, pend_entry_next;

    logic [31:0]      clus, mask, sec, fill_entry, res_entry, res_cl, ent, chain_next;
    logic             same, hit, last, chain;
    logic [IDX_W-1:0] pend_idx;

    function automatic logic is_data(input logic [31:0] c);
        logic [31:0] m;
        m = c & ENTRY_MASK;
        return (m >= CLUSTER_MIN) && (m <= CLUSTER_MAX);
    endfunction

    always_comb begin
        clus       = (item.diff >> cfg.cluster_shift) + 32'd2;
        mask       = ~(32'hffff_ffff << cfg.cluster_shift);
        same       = (item.diff & mask) != mask;
        sec        = cfg.fat_lba + {{(IDX_W + 2){1'b0}}, clus[29:IDX_W]};
        hit        = cache_valid_reg && (cache_tag_reg == sec);
        last       = fill_count_reg == IDX_W'(FAT_WORDS - 1);
        pend_idx   = pend_cl_reg[IDX_W-1:0];
        fill_entry = (pend_idx == fill_count_reg) ? item.word : pend_entry_reg;

        // one resolver shared by cache hits and fill completion
        res_entry  = (item.kind == KIND_FILL) ? fill_entry : cache_entry;
        res_cl     = (item.kind == KIND_FILL) ? pend_cl_reg : clus;
        ent        = res_entry & ENTRY_MASK;
        chain      = is_data(ent) && (ent != res_cl);
        chain_next = cfg.data_start_lba + ((ent - 32'd2) << cfg.cluster_shift);

        pending_next     = pending_reg;
        cache_valid_next = cache_valid_reg;
        cache_tag_next   = cache_tag_reg;
        pend_cl_next     = pend_cl_reg;
        fill_count_next  = fill_count_reg;
        pend_entry_next  = pend_entry_reg;

        cache_wr.en   = 1'b0;
        cache_wr.addr = fill_count_reg;
        cache_wr.data = item.word;

        result.valid        = 1'b0;
        result.status       = ST_SAME;
        result.next_sector  = 32'd0;
        result.fat_read_lba = 32'd0;

        if (item.kind == KIND_FILL) begin
            if (pending_reg) begin
                cache_wr.en = exec;
                if (pend_idx == fill_count_reg) begin
                    pend_entry_next = item.word;
                end
                if (last) begin
                    fill_count_next  = '0;
                    pending_next     = 1'b0;
                    cache_valid_next = 1'b1;
                    result.valid     = 1'b1;
                    if (chain) begin
                        result.status      = ST_CHAIN;
                        result.next_sector = chain_next;
                    end else begin
                        result.status = ST_END;
                    end
                end else begin
                    fill_count_next = fill_count_reg + IDX_W'(1);
                end
            end
        end else begin
            result.valid = 1'b1;
            if (pending_reg) begin
                result.status = ST_BUSY;
            end else if (same) begin
                result.status      = ST_SAME;
                result.next_sector = item.lba + 32'd1;
            end else if (!is_data(clus)) begin
                result.status = ST_END;
            end else if (hit) begin
                if (chain) begin
                    result.status      = ST_CHAIN;
                    result.next_sector = chain_next;
                end else begin
                    result.status = ST_END;
                end
            end else begin
                cache_valid_next    = 1'b0;
                cache_tag_next      = sec;
                pending_next        = 1'b1;
                pend_cl_next        = clus;
                fill_count_next     = '0;
                result.status       = ST_FAT_REQ;
                result.fat_read_lba = sec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg     <= 1'b0;
            cache_valid_reg <= 1'b0;
            cache_tag_reg   <= '0;
            pend_cl_reg     <= '0;
            fill_count_reg  <= '0;
        end else if (exec) begin
            pending_reg     <= pending_next;
            cache_valid_reg <= cache_valid_next;
            cache_tag_reg   <= cache_tag_next;
            pend_cl_reg     <= pend_cl_next;
            fill_count_reg  <= fill_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            pend_entry_reg <= pend_entry_next;
        end
    end

    assign stat.pending = pending_reg;
    assign stat.filling = fill_count_reg != '0;

endmodule

@@ design/fat32_chain_sector_stepper_top.sv @@
// channel   dir  tdata (low bit up)              tuser
// s_        in   sector_lba, fill_word (64)       kind (1)
// m_        out  next_sector, fat_read_lba (64)   status (3)
// apb       in   data_start_lba, fat_lba, cluster_shift at 0x0, 0x4, 0x8
// one word per cycle on s_ while s_tready is high; m_tvalid is driven from the stage two register
// stage one registers the word and starts the fat cache read, stage two holds the result
// the cache has one read and one write port; a fill word written next to a read is bypassed
// a stall on m_ holds a full stage one and drops s_tready; a fill word that is not the last
// gives no word
// aresetn clears the pipeline valids, tag valid bit and fill tracking, not the cache array
`include "fat32_chain_sector_stepper_top_macros.svh"

module fat32_chain_sector_stepper_top import fcss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // sector_lba, fill_word
    input  logic              s_tuser,   // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // next_sector, fat_read_lba
    output logic [2:0]        m_tuser    // status
);

    cfg_t             cfg;
    logic             accept_in, exec;
    logic [31:0]      diff_in;
    logic [IDX_W-1:0] idx_in;
    logic [31:0]      cache_entry;
    cache_wr_t        cache_wr;
    result_t          res;
    core_stat_t       stat;

    logic             s1_valid_reg;
    item_t            s1_item_reg;
    logic             m_valid_reg;
    result_t          m_res_reg;

    fcss_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign exec      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || exec;
    assign accept_in = s_tvalid && s_tready;
    assign diff_in   = s_tdata[31:0] - cfg.data_start_lba;
    assign idx_in    = IDX_W'(diff_in >> cfg.cluster_shift) + IDX_W'(2);

    fcss_fat_cache u_cache (
        .aclk    (aclk),
        .rd_en   (accept_in),
        .rd_addr (idx_in),
        .wr      (cache_wr),
        .rd_data (cache_entry)
    );

    fcss_step_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .exec        (exec),
        .item        (s1_item_reg),
        .cache_entry (cache_entry),
        .cache_wr    (cache_wr),
        .result      (res),
        .stat        (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept_in) begin
            s1_valid_reg <= 1'b1;
        end else if (exec) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            s1_item_reg.kind <= s_tuser;
            s1_item_reg.lba  <= s_tdata[31:0];
            s1_item_reg.diff <= diff_in;
            s1_item_reg.word <= s_tdata[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec) begin
            m_valid_reg <= res.valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec && res.valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.fat_read_lba, m_res_reg.next_sector};
    assign m_tuser  = m_res_reg.status;

    `FCSS_ASSERT_IMPL(a_fill_needs_pending, aclk, aresetn, stat.filling, stat.pending)
    `FCSS_ASSERT_IMPL(a_pending_from_request, aclk, aresetn, $rose(stat.pending),
        m_tvalid && (m_tuser == ST_FAT_REQ))
    `FCSS_ASSERT_NEXT(a_busy_while_pending, aclk, aresetn,
        exec && stat.pending && (s1_item_reg.kind == KIND_ADVANCE),
        m_tvalid && (m_tuser == ST_BUSY))
    `FCSS_ASSERT_IMPL(a_stall_blocks_input, aclk, aresetn,
        s1_valid_reg && m_valid_reg && !m_tready, !s_tready)

endmodule

@@ tb/fat32_chain_sector_stepper_top_tb.sv @@
// self-checking testbench for fat32_chain_sector_stepper_top: sector advances, fat cache
// misses with sector fills, and chain walks, checked against an in-bench cluster chain predictor
// depends on fcss_pkg and the design top level
module fat32_chain_sector_stepper_top_tb;
    import fcss_pkg::*;

    localparam int PLAN   = 0;
    localparam int MIRROR = 1;

    typedef struct packed {
        logic        kind;
        logic [31:0] lba;
        logic [31:0] word;
    } sector_word_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] next_sector;
        logic [31:0] fat_read_lba;
    } chain_word_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata = '0;   // sector_lba, fill_word
    logic              s_tuser = 1'b0; // kind
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [63:0]       m_tdata;        // next_sector, fat_read_lba
    logic [2:0]        m_tuser;        // status

    fat32_chain_sector_stepper_top i_dut (.*);

    // register copies shared by both predictor views
    logic [31:0] cfg_ds = '0;
    logic [31:0] cfg_fat = '0;
    logic [2:0]  cfg_sh = '0;

    // view PLAN runs ahead while stimulus is built, MIRROR follows accepted words
    logic [31:0] fat_copy [2][FAT_WORDS];
    logic [31:0] cache_tag_of [2];
    bit          cache_ok [2];
    bit          filling [2];
    logic [31:0] wait_cluster [2];
    int          fill_pos [2];

    sector_word_t in_words [$];
    chain_word_t  due_words [$];

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int tx_gap = 0;
    bit tx_calm = 1'b0;
    int rx_wait = 0;
    bit rx_calm = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stim_count = 0;
    int seen_words = 0;
    int fill_total = 0;
    int err_cnt = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] cluster_of(input logic [31:0] lba);
        return ((lba - cfg_ds) >> cfg_sh) + 32'd2;
    endfunction

    function automatic logic [31:0] cluster_tail(input logic [31:0] c);
        return cfg_ds + ((c - 32'd1) << cfg_sh) - 32'd1;
    endfunction

    function automatic bit is_data_cluster(input logic [31:0] c);
        logic [31:0] m;
        m = c & ENTRY_MASK;
        return m >= CLUSTER_MIN && m <= CLUSTER_MAX;
    endfunction

    function automatic chain_word_t entry_lookup(input int view, input logic [31:0] c);
        logic [31:0] e;
        chain_word_t res;
        e = fat_copy[view][c[IDX_W-1:0]] & ENTRY_MASK;
        res.next_sector = '0;
        res.fat_read_lba = '0;
        if (is_data_cluster(e) && e != c) begin
            res.status = ST_CHAIN;
            res.next_sector = cfg_ds + ((e - 32'd2) << cfg_sh);
        end else begin
            res.status = ST_END;
        end
        return res;
    endfunction

    function automatic bit predict_chain(input int view, input logic kind, input logic [31:0] lba,
                                         input logic [31:0] word, output chain_word_t res);
        logic [31:0] nxt, c, sec, four_c;
        res.status = ST_SAME;
        res.next_sector = '0;
        res.fat_read_lba = '0;
        if (kind == KIND_FILL) begin
            if (!filling[view])
                return 1'b0;
            fat_copy[view][fill_pos[view]] = word;
            if (fill_pos[view] + 1 < FAT_WORDS) begin
                fill_pos[view]++;
                return 1'b0;
            end
            fill_pos[view] = 0;
            filling[view] = 1'b0;
            cache_ok[view] = 1'b1;
            res = entry_lookup(view, wait_cluster[view]);
            return 1'b1;
        end
        if (filling[view]) begin
            res.status = ST_BUSY;
            return 1'b1;
        end
        nxt = lba + 32'd1;
        c = cluster_of(lba);
        if (cluster_of(nxt) == c) begin
            res.next_sector = nxt;
            return 1'b1;
        end
        if (!is_data_cluster(c)) begin
            res.status = ST_END;
            return 1'b1;
        end
        four_c = c << 2;
        sec = cfg_fat + four_c / SECTOR_BYTES;
        if (cache_ok[view] && cache_tag_of[view] == sec) begin
            res = entry_lookup(view, c);
            return 1'b1;
        end
        cache_ok[view] = 1'b0;
        cache_tag_of[view] = sec;
        filling[view] = 1'b1;
        wait_cluster[view] = c;
        fill_pos[view] = 0;
        res.status = ST_FAT_REQ;
        res.fat_read_lba = sec;
        return 1'b1;
    endfunction

    function automatic bit push_item(input logic kind, input logic [31:0] lba,
                                     input logic [31:0] word, output chain_word_t res);
        if (!(kind == KIND_FILL && !filling[PLAN]))
            stim_count++;
        in_words.push_back('{kind: kind, lba: lba, word: word});
        return predict_chain(PLAN, kind, lba, word, res);
    endfunction

    // one whole fat sector; random fills may carry advances that hit the busy case
    task automatic fill_sector(input bit directed, output chain_word_t res);
        logic [31:0] base, w;
        bit got;
        base = wait_cluster[PLAN] & ~(FAT_WORDS - 1);
        fill_total++;
        for (int i = 0; i < FAT_WORDS; i++) begin
            if (!directed && $urandom_range(0, 79) == 0)
                got = push_item(KIND_ADVANCE, $urandom(), $urandom(), res);
            case (directed ? i : 16 + $urandom_range(0, 9))
                0: w = 32'h0fff_ffff;
                1: w = 32'h0fff_fff8;
                2: w = 32'd2;
                3: w = 32'hf000_0009;
                4: w = 32'h0fff_fff7;
                5: w = 32'd0;
                6: w = 32'd1;
                7: w = CLUSTER_MAX;
                8: w = 32'h0fff_fff0;
                9: w = 32'hffff_ffff;
                10: w = CLUSTER_MIN;
                11: w = 32'h1000_000b;
                17, 18: w = {4'($urandom()), 28'(base + $urandom_range(0, FAT_WORDS - 1))};
                20: w = {4'($urandom()), 28'($urandom_range(CLUSTER_MIN, CLUSTER_MAX))};
                21: w = {4'($urandom()), 28'($urandom_range(32'h0fff_fff8, 32'h0fff_ffff))};
                22: w = $urandom_range(32'h0fff_fff0, 32'h0fff_fff7);
                23: w = $urandom_range(0, 1);
                24: w = base + i;
                25: w = $urandom();
                default: w = {4'($urandom()), 28'(base + i + 1)};
            endcase
            got = push_item(KIND_FILL, $urandom(), w, res);
        end
    endtask

    task automatic step_sector(input logic [31:0] lba, output chain_word_t res);
        bit got;
        got = push_item(KIND_ADVANCE, lba, $urandom(), res);
        if (res.status == ST_FAT_REQ)
            fill_sector(1'b0, res);
    endtask

    // follow a file: step inside a cluster, jump to its tail, take the link
    task automatic walk_chain(input logic [31:0] start, input int hops);
        logic [31:0] lba;
        chain_word_t res;
        lba = start;
        for (int h = 0; h < hops; h++) begin
            step_sector(lba, res);
            if (res.status == ST_SAME)
                lba = ($urandom_range(0, 2) == 0) ? res.next_sector : cluster_tail(cluster_of(lba));
            else if (res.status == ST_CHAIN)
                lba = res.next_sector;
            else
                break;
        end
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_regs(input logic [31:0] ds, input logic [31:0] fat, input logic [2:0] sh);
        apb_write(REG_DATA_START, ds);
        apb_write(REG_FAT_LBA, fat);
        apb_write(REG_CLUSTER_SHIFT, {29'd0, sh});
        cfg_ds = ds;
        cfg_fat = fat;
        cfg_sh = sh;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (in_words.size() > 0 || s_tvalid || due_words.size() > 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        err_cnt++;
        if (err_cnt <= 100)
            $display("mismatch at result word %0d, %s: got %h, expected %h",
                     seen_words, what, got, want);
    endtask

    // sender
    always @(negedge aclk) begin : sender
        sector_word_t cur;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (in_taken || !s_tvalid) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (in_words.size() > 0) begin
                cur = in_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur.kind;
                s_tdata <= {cur.word, cur.lba};
                tx_gap = tx_calm ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 63) == 0)
                    tx_calm = !tx_calm;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && seen_words >= 40) begin
            hold_done = 1'b1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else begin
            if (out_taken) begin
                rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 63) == 0)
                    rx_calm = !rx_calm;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : mirror_check
        chain_word_t res, want;
        bit has;
        in_taken <= aresetn && s_tvalid && s_tready;
        out_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                has = predict_chain(MIRROR, s_tuser, s_tdata[31:0], s_tdata[63:32], res);
                if (has)
                    due_words.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                seen_words++;
                if (due_words.size() == 0) begin
                    flag_mismatch("word with nothing expected", m_tdata[31:0], '0);
                end else begin
                    want = due_words.pop_front();
                    if (m_tuser !== want.status)
                        flag_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] !== want.next_sector)
                        flag_mismatch("next_sector", m_tdata[31:0], want.next_sector);
                    if (m_tdata[63:32] !== want.fat_read_lba)
                        flag_mismatch("fat_read_lba", m_tdata[63:32], want.fat_read_lba);
                end
            end
        end
    end

    initial begin : run
        chain_word_t res;
        logic [31:0] c;
        bit got;
        int stim_goal;
        for (int v = 0; v < 2; v++) begin
            cache_tag_of[v] = '0;
            cache_ok[v] = 1'b0;
            filling[v] = 1'b0;
            wait_cluster[v] = '0;
            fill_pos[v] = 0;
        end
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: edges, busy, every kind of fat entry
        program_regs(32'h0000_1000, 32'h0000_0020, 3'd3);
        got = push_item(KIND_FILL, 32'd0, 32'hffff_ffff, res);
        got = push_item(KIND_ADVANCE, 32'h0000_1000, 32'd0, res);
        got = push_item(KIND_ADVANCE, 32'h0000_0fff, 32'hffff_ffff, res);
        got = push_item(KIND_ADVANCE, cluster_tail(32'd2), $urandom(), res);
        got = push_item(KIND_ADVANCE, 32'h0000_1000, $urandom(), res);
        fill_sector(1'b1, res);
        got = push_item(KIND_FILL, $urandom(), $urandom(), res);
        for (int k = 3; k <= 11; k++)
            got = push_item(KIND_ADVANCE, cluster_tail(k), $urandom(), res);
        got = push_item(KIND_ADVANCE, cluster_tail(32'h0fff_fff0), $urandom(), res);
        step_sector(32'hffff_ffff, res);
        walk_chain(cluster_tail(32'd12), 6);
        wait_idle();

        stim_goal = stim_count;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: program_regs(32'h0000_0000, 32'h0000_0000, 3'd0);
                1: program_regs(32'hffff_ffff, 32'hffff_ffff, 3'd7);
                2: program_regs($urandom(), $urandom(), 3'($urandom_range(0, 7)));
                3: program_regs($urandom(), $urandom(), 3'd7);
                default: program_regs($urandom_range(0, 4096), $urandom_range(0, 64),
                                      3'($urandom_range(1, 6)));
            endcase
            stim_goal += 200;
            if (stim_goal < stim_count + 60)
                stim_goal = stim_count + 60;
            while (stim_count < stim_goal) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        if (cache_ok[PLAN] && $urandom_range(0, 2) != 0)
                            c = (cache_tag_of[PLAN] - cfg_fat) * FAT_WORDS
                                + $urandom_range(0, FAT_WORDS - 1);
                        else if ($urandom_range(0, 3) != 0)
                            c = 32'd2 + $urandom_range(0, 400);
                        else
                            c = $urandom_range(CLUSTER_MIN, CLUSTER_MAX);
                        walk_chain(cfg_ds + ((c - 32'd2) << cfg_sh)
                                   + $urandom_range(0, (32'd1 << cfg_sh) - 1),
                                   $urandom_range(1, 10));
                    end
                    6: step_sector($urandom(), res);
                    7: got = push_item(KIND_FILL, $urandom(), $urandom(), res);
                    8: begin
                        case ($urandom_range(0, 5))
                            0: c = 32'd0;
                            1: c = 32'd1;
                            2: c = CLUSTER_MAX;
                            3: c = CLUSTER_MAX + 32'd1;
                            4: c = 32'h1000_0002;
                            default: c = 32'hffff_ffff;
                        endcase
                        step_sector(cluster_tail(c), res);
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: c = 32'd0;
                            1: c = 32'hffff_ffff;
                            2: c = cfg_ds;
                            default: c = cfg_ds - 32'd1;
                        endcase
                        step_sector(c, res);
                    end
                endcase
            end
            wait_idle();
        end

        repeat (10) @(negedge aclk);
        $display("covered %0d input words and %0d result words", stim_count, seen_words);
        $display("%0d fat sector fills over six register settings", fill_total);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #3600000;
        $display("Some tests failed");
        $finish;
    end

endmodule
